// File: hw/rtl/sebm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sebm_pkg
// Shared constants and types of the soft elliptic brush mask core.
// ----------------------------------------------------------------------------
package sebm_pkg;

   localparam int SEBM_MAX_TIP_SIZE  = 512;
   localparam int SEBM_FRACTION_BITS = 16;

   localparam int TIP_SIZE_W = 10;
   localparam int Q16_W      = 17;
   localparam int TRIG_W     = 16;
   localparam int PIXEL_W    = 9;
   localparam int COV_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIP_SIZE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HARDNESS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDNESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE = 3'd4;

   // reset values and write limits
   localparam logic [TIP_SIZE_W-1:0] TIP_SIZE_RST  = 10'd64;
   localparam logic [TIP_SIZE_W-1:0] TIP_SIZE_MIN  = 10'd8;
   localparam logic [Q16_W-1:0]      Q16_ONE       = 17'd65536;
   localparam logic [Q16_W-1:0]      HARDNESS_RST  = 17'd32768;
   localparam logic [Q16_W-1:0]      ROUNDNESS_MIN = 17'd3277;
   localparam logic [TRIG_W-1:0]     COS_RST       = 16'd16384;
   localparam logic [TRIG_W-1:0]     SIN_RST       = 16'd0;

   // fixed point of the trig and ratio registers
   localparam int TRIG_FRAC = 14;
   localparam int Q16_FRAC  = 16;

   localparam logic [COV_W-1:0] COV_FULL   = 8'd255;
   localparam logic [COV_W-1:0] COV_NONE   = 8'd0;
   localparam int               COV_TWICE  = 510;

   typedef enum logic [2:0] {
      MODE_ZERO = 3'b001,
      MODE_FULL = 3'b010,
      MODE_DIV  = 3'b100
   } mode_type;

endpackage
`default_nettype wire

// File: hw/rtl/sebm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sebm_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module sebm_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8,
   parameter int Q_W   = 8,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             valid_in,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   input  logic [TAG_W-1:0] tag_in,
   output logic             valid_out,
   output logic [Q_W-1:0]   quo_out,
   output logic [TAG_W-1:0] tag_out
);

   localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic             valid_ff [Q_W];
   logic [Q_W-1:0]   quo_ff   [Q_W];
   logic [TAG_W-1:0] tag_ff   [Q_W];
   logic [CMP_W-1:0] rem_ff   [Q_W-1];
   logic [DEN_W-1:0] den_ff   [Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int BIT = Q_W - 1 - k;
      logic             valid_src;
      logic [CMP_W-1:0] rem_src;
      logic [Q_W-1:0]   quo_src;
      logic [DEN_W-1:0] den_src;
      logic [TAG_W-1:0] tag_src;
      logic [CMP_W-1:0] trial;
      logic             take;
      logic [CMP_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign valid_src = valid_in;
         assign rem_src   = CMP_W'(num_in);
         assign quo_src   = '0;
         assign den_src   = den_in;
         assign tag_src   = tag_in;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign tag_src   = tag_ff[k-1];
      end

      assign trial  = CMP_W'(den_src) << BIT;
      assign take   = rem_src >= trial;
      assign rem_in = take ? rem_src - trial : rem_src;
      assign quo_in = take ? (quo_src | (Q_W'(1) << BIT)) : quo_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= quo_in;
            tag_ff[k] <= tag_src;
         end
      end

      if (k < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign valid_out = valid_ff[Q_W-1];
   assign quo_out   = quo_ff[Q_W-1];
   assign tag_out   = tag_ff[Q_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/sebm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sebm_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module sebm_sqrt #(
   parameter int V_W   = 16,
   parameter int R_W   = 8,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             valid_in,
   input  logic [V_W-1:0]   value_in,
   input  logic [TAG_W-1:0] tag_in,
   output logic             valid_out,
   output logic [R_W-1:0]   root_out,
   output logic [TAG_W-1:0] tag_out
);

   localparam int RM_W = (V_W > 2 * R_W) ? V_W : 2 * R_W;

   logic             valid_ff [R_W];
   logic [R_W-1:0]   root_ff  [R_W];
   logic [TAG_W-1:0] tag_ff   [R_W];
   logic [RM_W-1:0]  rem_ff   [R_W-1];

   for (genvar k = 0; k < R_W; k++) begin : g_stage
      localparam int BIT = R_W - 1 - k;
      logic             valid_src;
      logic [RM_W-1:0]  rem_src;
      logic [R_W-1:0]   root_src;
      logic [TAG_W-1:0] tag_src;
      logic [RM_W-1:0]  trial;
      logic             take;
      logic [RM_W-1:0]  rem_in;
      logic [R_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign valid_src = valid_in;
         assign rem_src   = RM_W'(value_in);
         assign root_src  = '0;
         assign tag_src   = tag_in;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign tag_src   = tag_ff[k-1];
      end

      // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
      assign trial   = (RM_W'(root_src) << (BIT + 1)) | (RM_W'(1) << (2 * BIT));
      assign take    = rem_src >= trial;
      assign rem_in  = take ? rem_src - trial : rem_src;
      assign root_in = take ? (root_src | (R_W'(1) << BIT)) : root_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_src;
         end
      end

      if (k < R_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign valid_out = valid_ff[R_W-1];
   assign root_out  = root_ff[R_W-1];
   assign tag_out   = tag_ff[R_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/soft_elliptic_brush_mask_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// soft_elliptic_brush_mask_core
// Coverage of one pixel of a soft, rotated, elliptic square brush tip.
// ----------------------------------------------------------------------------
// Depth: the bit-per-stage divider and square root pipelines set the
//   depth of the path from request to result.
// Throughput: one request per cycle; a one-entry skid register behind the
//   last stage lets the pipe advance once more while a result waits,
//   then the input stalls until the output is taken.
// Reset: synchronous, clears all valid bits and loads the register defaults
//   (size 64, hardness 0.5, roundness 1.0, angle zero).
// ----------------------------------------------------------------------------
module soft_elliptic_brush_mask_core
   import sebm_pkg::*;
#(
   parameter int MAX_TIP_SIZE  = SEBM_MAX_TIP_SIZE,
   parameter int FRACTION_BITS = SEBM_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_pixel_x,
   input  logic [PIXEL_W-1:0]    req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COV_W-1:0]      rsp_coverage,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int F     = FRACTION_BITS;
   localparam int NW1   = F + 12;        // |2x-s+1| * 2^F plus half divisor
   localparam int QW1   = F + 1;         // normalized coordinate magnitude
   localparam int DXW   = F + 2;         // signed normalized coordinate
   localparam int PRW   = DXW + TRIG_W;  // product
   localparam int SMW   = PRW + 1;       // sum of two products
   localparam int RMW   = F + 3;         // rotated magnitude
   localparam int NW2   = RMW + Q16_FRAC + 1;
   localparam int QW2   = F + 7;         // minor axis after roundness
   localparam int SQW   = 2 * F + 2;
   localparam int VW    = 2 * F + 3;
   localparam int RW    = F + 2;         // distance
   localparam int NW3   = F + 11;
   localparam int DW3   = F + 2;
   localparam int T2W   = RMW + 1;
   localparam int MODEW = $bits(mode_type);

   // ------------------------------------------------------------------
   // Configuration registers; size, hardness and roundness clamped on write
   // ------------------------------------------------------------------
   logic [TIP_SIZE_W-1:0]    tip_size_ff;
   logic [Q16_W-1:0]         hardness_ff;
   logic [Q16_W-1:0]         roundness_ff;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   logic [TIP_SIZE_W-1:0]    tip_size_in;
   logic [Q16_W-1:0]         hardness_in;
   logic [Q16_W-1:0]         roundness_in;

   always_comb begin
      tip_size_in = csr_wr_data[TIP_SIZE_W-1:0];
      if (tip_size_in < TIP_SIZE_MIN) begin
         tip_size_in = TIP_SIZE_MIN;
      end else if (int'(tip_size_in) > MAX_TIP_SIZE) begin
         tip_size_in = TIP_SIZE_W'(MAX_TIP_SIZE);
      end
      hardness_in = (csr_wr_data > Q16_ONE) ? Q16_ONE : csr_wr_data;
      roundness_in = csr_wr_data;
      if (roundness_in < ROUNDNESS_MIN) begin
         roundness_in = ROUNDNESS_MIN;
      end else if (roundness_in > Q16_ONE) begin
         roundness_in = Q16_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tip_size_ff  <= TIP_SIZE_RST;
         hardness_ff  <= HARDNESS_RST;
         roundness_ff <= Q16_ONE;
         cos_ff       <= COS_RST;
         sin_ff       <= SIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TIP_SIZE:  tip_size_ff  <= tip_size_in;
            CSR_HARDNESS:  hardness_ff  <= hardness_in;
            CSR_ROUNDNESS: roundness_ff <= roundness_in;
            CSR_COS_ANGLE: cos_ff       <= csr_wr_data[TRIG_W-1:0];
            CSR_SIN_ANGLE: sin_ff       <= csr_wr_data[TRIG_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipe advances unless the skid slot is taken
   // ------------------------------------------------------------------
   logic             skid_valid_ff;
   logic [COV_W-1:0] skid_cov_ff;
   logic             rsp_valid_ff;
   logic [COV_W-1:0] rsp_cov_ff;
   logic             en;
   logic             out_take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_take  = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Stage 0: capture the request
   // ------------------------------------------------------------------
   logic               s0_valid_ff;
   logic [PIXEL_W-1:0] s0_x_ff;
   logic [PIXEL_W-1:0] s0_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff <= req_pixel_x;
         s0_y_ff <= req_pixel_y;
      end
   end

   // center offset 2p - s + 1, taken as sign and magnitude
   logic                  s0_outside;
   logic [11:0]           nx_u;
   logic [11:0]           ny_u;
   logic [11:0]           nx_mag;
   logic [11:0]           ny_mag;
   logic [TIP_SIZE_W-1:0] den1;
   logic [NW1-1:0]        num1_x;
   logic [NW1-1:0]        num1_y;

   assign s0_outside = ({1'b0, s0_x_ff} >= tip_size_ff) || ({1'b0, s0_y_ff} >= tip_size_ff);
   assign nx_u   = {2'b00, s0_x_ff, 1'b0} - {2'b00, tip_size_ff} + 12'd1;
   assign ny_u   = {2'b00, s0_y_ff, 1'b0} - {2'b00, tip_size_ff} + 12'd1;
   assign nx_mag = nx_u[11] ? -nx_u : nx_u;
   assign ny_mag = ny_u[11] ? -ny_u : ny_u;
   assign den1   = tip_size_ff - 10'd2;
   assign num1_x = {nx_mag[10:0], {F{1'b0}}} + NW1'(den1[TIP_SIZE_W-1:1]);
   assign num1_y = {ny_mag[10:0], {F{1'b0}}} + NW1'(den1[TIP_SIZE_W-1:1]);

   // ------------------------------------------------------------------
   // Normalize by the radius
   // ------------------------------------------------------------------
   logic           d1x_valid;
   logic           d1y_valid;
   logic [QW1-1:0] d1x_q;
   logic [QW1-1:0] d1y_q;
   logic [1:0]     d1x_tag;
   logic           d1y_tag;

   sebm_div #(.NUM_W(NW1), .DEN_W(TIP_SIZE_W), .Q_W(QW1), .TAG_W(2)) u_div_x (
      .clock(clock), .reset(reset), .enable(en),
      .valid_in(s0_valid_ff), .num_in(num1_x), .den_in(den1),
      .tag_in({s0_outside, nx_u[11]}),
      .valid_out(d1x_valid), .quo_out(d1x_q), .tag_out(d1x_tag)
   );

   sebm_div #(.NUM_W(NW1), .DEN_W(TIP_SIZE_W), .Q_W(QW1), .TAG_W(1)) u_div_y (
      .clock(clock), .reset(reset), .enable(en),
      .valid_in(s0_valid_ff), .num_in(num1_y), .den_in(den1),
      .tag_in(ny_u[11]),
      .valid_out(d1y_valid), .quo_out(d1y_q), .tag_out(d1y_tag)
   );

   logic signed [DXW-1:0] dx;
   logic signed [DXW-1:0] dy;

   assign dx = d1x_tag[0] ? -$signed({1'b0, d1x_q}) : $signed({1'b0, d1x_q});
   assign dy = d1y_tag    ? -$signed({1'b0, d1y_q}) : $signed({1'b0, d1y_q});

   // ------------------------------------------------------------------
   // Rotate: products, sums, rounding by 2^14
   // ------------------------------------------------------------------
   logic                  m1_valid_ff;
   logic                  m1_out_ff;
   logic signed [PRW-1:0] m1_xc_ff;
   logic signed [PRW-1:0] m1_ys_ff;
   logic signed [PRW-1:0] m1_yc_ff;
   logic signed [PRW-1:0] m1_xs_ff;
   logic                  m2_valid_ff;
   logic                  m2_out_ff;
   logic [SMW-1:0]        m2_sx_ff;
   logic [SMW-1:0]        m2_sy_ff;
   logic                  m3_valid_ff;
   logic                  m3_out_ff;
   logic [RMW-1:0]        m3_rx_ff;
   logic [RMW-1:0]        m3_ry_ff;
   logic [SMW-1:0]        sx_mag;
   logic [SMW-1:0]        sy_mag;
   logic [SMW-1:0]        sx_rnd;
   logic [SMW-1:0]        sy_rnd;

   assign sx_mag = m2_sx_ff[SMW-1] ? -m2_sx_ff : m2_sx_ff;
   assign sy_mag = m2_sy_ff[SMW-1] ? -m2_sy_ff : m2_sy_ff;
   assign sx_rnd = sx_mag + (SMW'(1) << (TRIG_FRAC - 1));
   assign sy_rnd = sy_mag + (SMW'(1) << (TRIG_FRAC - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= d1x_valid && d1y_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_out_ff <= d1x_tag[1];
         m1_xc_ff  <= dx * cos_ff;
         m1_ys_ff  <= dy * sin_ff;
         m1_yc_ff  <= dy * cos_ff;
         m1_xs_ff  <= dx * sin_ff;
         m2_out_ff <= m1_out_ff;
         m2_sx_ff  <= {m1_xc_ff[PRW-1], m1_xc_ff} + {m1_ys_ff[PRW-1], m1_ys_ff};
         m2_sy_ff  <= {m1_yc_ff[PRW-1], m1_yc_ff} - {m1_xs_ff[PRW-1], m1_xs_ff};
         m3_out_ff <= m2_out_ff;
         m3_rx_ff  <= sx_rnd[TRIG_FRAC +: RMW];
         m3_ry_ff  <= sy_rnd[TRIG_FRAC +: RMW];
      end
   end

   // ------------------------------------------------------------------
   // Stretch the minor axis by 1/roundness
   // ------------------------------------------------------------------
   logic [NW2-1:0] num2;
   logic           d2_valid;
   logic [QW2-1:0] d2_q;
   logic [T2W-1:0] d2_tag;

   assign num2 = {1'b0, m3_ry_ff, {Q16_FRAC{1'b0}}} + NW2'(roundness_ff[Q16_W-1:1]);

   sebm_div #(.NUM_W(NW2), .DEN_W(Q16_W), .Q_W(QW2), .TAG_W(T2W)) u_div_round (
      .clock(clock), .reset(reset), .enable(en),
      .valid_in(m3_valid_ff), .num_in(num2), .den_in(roundness_ff),
      .tag_in({m3_out_ff, m3_rx_ff}),
      .valid_out(d2_valid), .quo_out(d2_q), .tag_out(d2_tag)
   );

   // far pixels (either axis at 2.0 or more) and pixels outside the tip go straight to zero
   logic           d2_zero;
   logic [RMW-1:0] d2_rx;

   assign d2_rx   = d2_tag[RMW-1:0];
   assign d2_zero = d2_tag[RMW] || (d2_rx[RMW-1:F+1] != '0) || (d2_q[QW2-1:F+1] != '0);

   // ------------------------------------------------------------------
   // Squared distance
   // ------------------------------------------------------------------
   logic           q1_valid_ff;
   logic           q1_zero_ff;
   logic [SQW-1:0] q1_xx_ff;
   logic [SQW-1:0] q1_yy_ff;
   logic           q2_valid_ff;
   logic           q2_zero_ff;
   logic [VW-1:0]  q2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= d2_valid;
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_zero_ff <= d2_zero;
         q1_xx_ff   <= SQW'(d2_rx[F:0]) * SQW'(d2_rx[F:0]);
         q1_yy_ff   <= SQW'(d2_q[F:0]) * SQW'(d2_q[F:0]);
         q2_zero_ff <= q1_zero_ff;
         q2_sum_ff  <= {1'b0, q1_xx_ff} + {1'b0, q1_yy_ff};
      end
   end

   logic          sq_valid;
   logic [RW-1:0] sq_d;
   logic          sq_zero;

   sebm_sqrt #(.V_W(VW), .R_W(RW), .TAG_W(1)) u_sqrt (
      .clock(clock), .reset(reset), .enable(en),
      .valid_in(q2_valid_ff), .value_in(q2_sum_ff), .tag_in(q2_zero_ff),
      .valid_out(sq_valid), .root_out(sq_d), .tag_out(sq_zero)
   );

   // ------------------------------------------------------------------
   // Falloff: pick the coverage case, then the linear ramp
   // ------------------------------------------------------------------
   localparam logic [RW-1:0] Q_ONE = RW'(1) << F;

   logic [Q16_W+F-1:0] h_wide;
   logic [RW-1:0]      h;
   mode_type           p1_mode_in;

   assign h_wide = {hardness_ff, {F{1'b0}}};
   assign h      = RW'(h_wide[Q16_FRAC +: F+1]);

   always_comb begin
      priority if (sq_zero || sq_d >= Q_ONE) begin
         p1_mode_in = MODE_ZERO;
      end else if (sq_d <= h) begin
         p1_mode_in = MODE_FULL;
      end else if (h >= Q_ONE) begin
         p1_mode_in = MODE_ZERO;
      end else begin
         p1_mode_in = MODE_DIV;
      end
   end

   logic           p1_valid_ff;
   mode_type       p1_mode_ff;
   logic [F:0]     p1_qd_ff;
   logic [F:0]     p1_span_ff;
   logic           p2_valid_ff;
   mode_type       p2_mode_ff;
   logic [NW3-1:0] p2_num_ff;
   logic [DW3-1:0] p2_den_ff;
   logic [RW-1:0]  qd_in;
   logic [RW-1:0]  span_in;

   assign qd_in   = Q_ONE - sq_d;
   assign span_in = Q_ONE - h;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= sq_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_mode_ff <= p1_mode_in;
         p1_qd_ff   <= qd_in[F:0];
         p1_span_ff <= span_in[F:0];
         p2_mode_ff <= p1_mode_ff;
         p2_num_ff  <= NW3'(p1_qd_ff) * NW3'(COV_TWICE) + NW3'(p1_span_ff);
         p2_den_ff  <= {p1_span_ff, 1'b0};
      end
   end

   logic             d3_valid;
   logic [COV_W-1:0] d3_q;
   logic [MODEW-1:0] d3_tag;
   mode_type         d3_mode;

   sebm_div #(.NUM_W(NW3), .DEN_W(DW3), .Q_W(COV_W), .TAG_W(MODEW)) u_div_ramp (
      .clock(clock), .reset(reset), .enable(en),
      .valid_in(p2_valid_ff), .num_in(p2_num_ff), .den_in(p2_den_ff),
      .tag_in(p2_mode_ff),
      .valid_out(d3_valid), .quo_out(d3_q), .tag_out(d3_tag)
   );

   assign d3_mode = mode_type'(d3_tag);

   logic             f_valid_ff;
   logic [COV_W-1:0] f_cov_ff;
   logic [COV_W-1:0] f_cov_in;

   always_comb begin
      unique case (d3_mode)
         MODE_FULL: f_cov_in = COV_FULL;
         MODE_DIV:  f_cov_in = d3_q;
         default:   f_cov_in = COV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_cov_ff <= f_cov_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register and skid slot
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_take) begin
         rsp_valid_ff <= f_valid_ff;
      end else if (f_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_cov_ff <= skid_cov_ff;
         end
      end else if (out_take) begin
         rsp_cov_ff <= f_cov_ff;
      end else begin
         skid_cov_ff <= f_cov_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coverage = rsp_cov_ff;

`ifndef NO_ASSERTIONS
   // a parked request always has one ahead of it in the output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a request while the output is empty");

   // the pipe must hold while the skid slot is taken
   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(f_valid_ff) && $stable(f_cov_ff))
      else $error("pipeline advanced while the skid slot was full");

   // a taken output with a parked request reloads from the skid
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid slot did not drain into the output");

   // both normalizer lanes stay in step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      d1x_valid == d1y_valid)
      else $error("normalizer lanes out of step");

   // clamped registers stay inside their limits
   a_cfg_limits: assert property (@(posedge clock) disable iff (reset)
      tip_size_ff >= TIP_SIZE_MIN && roundness_ff >= ROUNDNESS_MIN &&
      roundness_ff <= Q16_ONE && hardness_ff <= Q16_ONE)
      else $error("configuration register outside its limits");
`endif

endmodule
`default_nettype wire
